### rtl/vpp_pkg.sv
package vpp_pkg;

    // field and datapath widths
    localparam int POS_W   = 16;
    localparam int COEF_W  = 16;
    localparam int PRD_W   = POS_W + COEF_W;
    localparam int DOT_W   = 34;
    localparam int ROW_W   = 64;
    localparam int SIZE_W  = 13;
    localparam int OUT_W   = 24;
    localparam int CFG_IDX_W = 3;

    // output clamp limits
    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    // register reset values
    localparam logic [ROW_W-1:0]  ROW_X_RST  = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0]  ROW_Y_RST  = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0]  ROW_W_RST  = 64'h1000_0000_0000_0000;
    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X,
        CFG_ROW_Y,
        CFG_ROW_W,
        CFG_WIDTH,
        CFG_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_vpp_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
        logic                    visible;
        logic                    saturated;
    } t_vpp_out;

endpackage

### rtl/vpp_dot.sv
module vpp_dot #(
    parameter int CoordBits = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  vpp_pkg::t_vpp_in                    i_pos,
    input  logic [vpp_pkg::ROW_W-1:0]           i_row_x,
    input  logic [vpp_pkg::ROW_W-1:0]           i_row_y,
    input  logic [vpp_pkg::ROW_W-1:0]           i_row_w,
    output logic                                o_vld,
    output logic signed [vpp_pkg::DOT_W-1:0]    o_cx,
    output logic signed [vpp_pkg::DOT_W-1:0]    o_cy,
    output logic signed [vpp_pkg::DOT_W-1:0]    o_cw
);
    import vpp_pkg::*;

    localparam int EB = (CoordBits < POS_W) ? CoordBits : POS_W;
    localparam int SH = POS_W - EB;

    logic signed [POS_W-1:0]  pos   [3];
    logic [ROW_W-1:0]         rows  [3];
    logic signed [COEF_W-1:0] coef  [3][4];
    logic signed [PRD_W-1:0]  n_prd [3][3];
    logic signed [PRD_W-1:0]  r_prd [3][3];
    logic signed [DOT_W-1:0]  n_dot [3];
    logic signed [DOT_W-1:0]  r_dot [3];
    logic                     r_vld1;
    logic                     r_vld2;

    // coordinate sign extension from the configured width, coefficient unpack
    always_comb begin
        pos[0] = $signed(i_pos.pos_x << SH) >>> SH;
        pos[1] = $signed(i_pos.pos_y << SH) >>> SH;
        pos[2] = $signed(i_pos.pos_z << SH) >>> SH;
        rows[0] = i_row_x;
        rows[1] = i_row_y;
        rows[2] = i_row_w;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[r][c] = $signed(rows[r][COEF_W*c +: COEF_W]);
            end
        end
    end

    // nine products
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prd[r][c] = coef[r][c] * pos[c];
            end
        end
    end

    // row sums with the constant term scaled to 20 fraction bits
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_dot[r] = DOT_W'(r_prd[r][0]) + DOT_W'(r_prd[r][1]) + DOT_W'(r_prd[r][2])
                     + (DOT_W'(coef[r][3]) <<< 8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_prd  <= n_prd;
            r_dot  <= n_dot;
        end
    end

    assign o_vld = r_vld2;
    assign o_cx  = r_dot[0];
    assign o_cy  = r_dot[1];
    assign o_cw  = r_dot[2];

endmodule

### rtl/vpp_map.sv
module vpp_map #(
    parameter int FracBits = 4,
    localparam int SW = vpp_pkg::SIZE_W + FracBits,
    localparam int TW = vpp_pkg::DOT_W + 1,
    localparam int PW = TW + SW,
    localparam int NW = PW + 1,
    localparam int DW = vpp_pkg::DOT_W + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic signed [vpp_pkg::DOT_W-1:0] i_cx,
    input  logic signed [vpp_pkg::DOT_W-1:0] i_cy,
    input  logic signed [vpp_pkg::DOT_W-1:0] i_cw,
    input  logic [vpp_pkg::SIZE_W-1:0]       i_width,
    input  logic [vpp_pkg::SIZE_W-1:0]       i_height,
    output logic                             o_vld,
    output logic                             o_vis,
    output logic [NW-1:0]                    o_num_x,
    output logic [NW-1:0]                    o_num_y,
    output logic                             o_neg_x,
    output logic                             o_neg_y,
    output logic [DW-1:0]                    o_den
);
    import vpp_pkg::*;

    logic [SW-1:0]          scl_x;
    logic [SW-1:0]          scl_y;
    logic signed [SW:0]     sscl_x;
    logic signed [SW:0]     sscl_y;

    logic                   r_vld1, r_vld2, r_vld3, r_vld4;
    logic                   r_vis1, r_vis2, r_vis3, r_vis4;
    logic signed [TW-1:0]   r_tx, r_ty;
    logic signed [DOT_W-1:0] r_cw1, r_cw2;
    logic signed [PW-1:0]   r_px, r_py;
    logic signed [NW-1:0]   r_nx, r_ny;
    logic [DW-1:0]          r_den3, r_den4;
    logic [NW-1:0]          r_mx, r_my;
    logic                   r_negx, r_negy;

    // viewport scale in output fraction units
    always_comb begin
        scl_x  = SW'(i_width) << FracBits;
        scl_y  = SW'(i_height) << FracBits;
        sscl_x = $signed({1'b0, scl_x});
        sscl_y = $signed({1'b0, scl_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            // offsets from the clip edges, w sign test
            r_vld1 <= i_vld;
            r_tx   <= TW'(i_cx) + TW'(i_cw);
            r_ty   <= TW'(i_cw) - TW'(i_cy);
            r_cw1  <= i_cw;
            r_vis1 <= !i_cw[DOT_W-1] && (i_cw != '0);
            // scale by surface size
            r_vld2 <= r_vld1;
            r_px   <= r_tx * sscl_x;
            r_py   <= r_ty * sscl_y;
            r_cw2  <= r_cw1;
            r_vis2 <= r_vis1;
            // rounding bias and divisor 2w
            r_vld3 <= r_vld2;
            r_nx   <= NW'(r_px) + NW'(r_cw2);
            r_ny   <= NW'(r_py) + NW'(r_cw2);
            r_den3 <= DW'({r_cw2, 1'b0});
            r_vis3 <= r_vis2;
            // magnitude for floor division, negatives biased by divisor - 1
            r_vld4 <= r_vld3;
            r_negx <= r_nx[NW-1];
            r_negy <= r_ny[NW-1];
            r_mx   <= r_nx[NW-1] ? NW'(NW'(r_den3) - NW'(1) - r_nx) : NW'(r_nx);
            r_my   <= r_ny[NW-1] ? NW'(NW'(r_den3) - NW'(1) - r_ny) : NW'(r_ny);
            r_den4 <= r_den3;
            r_vis4 <= r_vis3;
        end
    end

    assign o_vld   = r_vld4;
    assign o_vis   = r_vis4;
    assign o_num_x = r_mx;
    assign o_num_y = r_my;
    assign o_neg_x = r_negx;
    assign o_neg_y = r_negy;
    assign o_den   = r_den4;

endmodule

### rtl/vpp_div.sv
module vpp_div #(
    parameter int NumBits = 54,
    parameter int DenBits = 35
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic                              i_tag,
    input  logic [NumBits-1:0]                i_num,
    input  logic                              i_neg,
    input  logic [DenBits-1:0]                i_den,
    output logic                              o_vld,
    output logic                              o_tag,
    output logic signed [vpp_pkg::OUT_W-1:0]  o_val,
    output logic                              o_sat
);
    import vpp_pkg::*;

    localparam int QW = OUT_W;
    localparam int WW = (NumBits > DenBits + QW) ? NumBits : DenBits + QW;
    localparam logic [QW-1:0] HALF = QW'(1) << (QW - 1);

    logic [WW-1:0]      r_rem [QW+1];
    logic [QW-1:0]      r_quo [QW+1];
    logic [DenBits-1:0] r_den [QW+1];
    logic               r_neg [QW+1];
    logic               r_ovf [QW+1];
    logic               r_tag [QW+1];
    logic               r_vld [QW+1];

    logic               n_sat;
    logic signed [QW-1:0] n_val;
    logic               r_vld_o;
    logic               r_tag_o;
    logic               r_sat_o;
    logic signed [QW-1:0] r_val_o;

    // entry stage: quotient overflow test against divisor << 24
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            r_tag[0] <= i_tag;
            r_rem[0] <= WW'(i_num);
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= WW'(i_num) >= (WW'(i_den) << QW);
        end
    end

    // one restoring quotient bit per stage, msb first
    for (genvar g = 0; g < QW; g++) begin : g_step
        localparam int K = QW - 1 - g;
        logic [WW-1:0] dsh;
        logic          ge;
        logic [QW-1:0] nq;

        always_comb begin
            dsh   = WW'(r_den[g]) << K;
            ge    = r_rem[g] >= dsh;
            nq    = r_quo[g];
            nq[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
                r_tag[g+1] <= r_tag[g];
                r_rem[g+1] <= ge ? r_rem[g] - dsh : r_rem[g];
                r_quo[g+1] <= nq;
                r_den[g+1] <= r_den[g];
                r_neg[g+1] <= r_neg[g];
                r_ovf[g+1] <= r_ovf[g];
            end
        end
    end

    // sign restore and clamp
    always_comb begin
        if (r_neg[QW]) begin
            n_sat = r_ovf[QW] || (r_quo[QW] > HALF);
            n_val = n_sat ? OUT_MIN : $signed(QW'(0) - r_quo[QW]);
        end else begin
            n_sat = r_ovf[QW] || r_quo[QW][QW-1];
            n_val = n_sat ? OUT_MAX : $signed(r_quo[QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld_o <= r_vld[QW];
            r_tag_o <= r_tag[QW];
            r_sat_o <= n_sat;
            r_val_o <= n_val;
        end
    end

    assign o_vld = r_vld_o;
    assign o_tag = r_tag_o;
    assign o_val = r_val_o;
    assign o_sat = r_sat_o;

endmodule

### rtl/vertex_perspective_projector_core.sv
// Vertex projector: one vertex position (x, y, z, signed Q8.8) in, one screen
// position (signed pixel coordinates with OUT_FRAC_BITS fraction bits) out.
// Input channel i_valid / o_ready with payload i_in; output channel o_valid /
// i_ready with payload o_out. Matrix rows and surface size are written through
// i_cfg_valid / o_cfg_ready (always ready), i_cfg_index, i_cfg_data; an
// unknown index is ignored. The user must write them only while the block
// is idle; the block itself does not enforce this. Throughput is one vertex
// per clock unless the receiver stalls. Two stages hold the row products and
// sums, four the viewport scaling and rounding bias, 26 each divider (entry,
// 24 quotient bits, clamp), then the output register; the first stage loads
// at the accepting edge, and the x and y dividers run side by side.
// A vertex with clip w not positive comes out with visible low and zeros.
// Reset loads the default matrix (identity x/y, w = 1.0) and a 640x480
// surface and empties the pipeline. When the receiver stalls, the output
// register holds its request and one more result parks in a skid register;
// the pipeline then freezes and o_ready drops, so nothing is lost.
module vertex_perspective_projector_core #(
    parameter int COORD_BITS    = 16,
    parameter int OUT_FRAC_BITS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  vpp_pkg::t_vpp_in                  i_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output vpp_pkg::t_vpp_out                 o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vpp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vpp_pkg::ROW_W-1:0]         i_cfg_data
);
    import vpp_pkg::*;

    localparam int SW = SIZE_W + OUT_FRAC_BITS;
    localparam int TW = DOT_W + 1;
    localparam int PW = TW + SW;
    localparam int NW = PW + 1;
    localparam int DW = DOT_W + 1;

    logic [ROW_W-1:0]  r_row_x, r_row_y, r_row_w;
    logic [SIZE_W-1:0] r_width, r_height;

    logic                    en;
    logic                    dot_vld;
    logic signed [DOT_W-1:0] dot_cx, dot_cy, dot_cw;
    logic                    map_vld, map_vis, map_negx, map_negy;
    logic [NW-1:0]           map_mx, map_my;
    logic [DW-1:0]           map_den;
    logic                    dvx_vld, dvx_tag, dvx_sat;
    logic                    dvy_vld, dvy_tag, dvy_sat;
    logic signed [OUT_W-1:0] dvx_val, dvy_val;
    logic                    tail_vld;
    t_vpp_out                tail_dat;

    logic                    r_ovld;
    t_vpp_out                r_out;
    logic                    r_skd_vld;
    t_vpp_out                r_skd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x  <= ROW_X_RST;
            r_row_y  <= ROW_Y_RST;
            r_row_w  <= ROW_W_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_X:  r_row_x  <= i_cfg_data;
                CFG_ROW_Y:  r_row_y  <= i_cfg_data;
                CFG_ROW_W:  r_row_w  <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline advances unless a result is parked in the skid register
    assign en      = !r_skd_vld;
    assign o_ready = en;

    vpp_dot #(
        .CoordBits (COORD_BITS)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_pos   (i_in),
        .i_row_x (r_row_x),
        .i_row_y (r_row_y),
        .i_row_w (r_row_w),
        .o_vld   (dot_vld),
        .o_cx    (dot_cx),
        .o_cy    (dot_cy),
        .o_cw    (dot_cw)
    );

    vpp_map #(
        .FracBits (OUT_FRAC_BITS)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (dot_vld),
        .i_cx     (dot_cx),
        .i_cy     (dot_cy),
        .i_cw     (dot_cw),
        .i_width  (r_width),
        .i_height (r_height),
        .o_vld    (map_vld),
        .o_vis    (map_vis),
        .o_num_x  (map_mx),
        .o_num_y  (map_my),
        .o_neg_x  (map_negx),
        .o_neg_y  (map_negy),
        .o_den    (map_den)
    );

    vpp_div #(
        .NumBits (NW),
        .DenBits (DW)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (map_vld),
        .i_tag   (map_vis),
        .i_num   (map_mx),
        .i_neg   (map_negx),
        .i_den   (map_den),
        .o_vld   (dvx_vld),
        .o_tag   (dvx_tag),
        .o_val   (dvx_val),
        .o_sat   (dvx_sat)
    );

    vpp_div #(
        .NumBits (NW),
        .DenBits (DW)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (map_vld),
        .i_tag   (map_vis),
        .i_num   (map_my),
        .i_neg   (map_negy),
        .i_den   (map_den),
        .o_vld   (dvy_vld),
        .o_tag   (dvy_tag),
        .o_val   (dvy_val),
        .o_sat   (dvy_sat)
    );

    // culled vertices read as all zero
    always_comb begin
        tail_vld = dvx_vld & dvy_vld;
        tail_dat = '0;
        if (dvx_tag & dvy_tag) begin
            tail_dat.screen_x  = dvx_val;
            tail_dat.screen_y  = dvy_val;
            tail_dat.visible   = 1'b1;
            tail_dat.saturated = dvx_sat | dvy_sat;
        end
    end

    // output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld    <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (!r_ovld || i_ready) begin
            if (r_skd_vld) begin
                r_ovld    <= 1'b1;
                r_out     <= r_skd;
                r_skd_vld <= 1'b0;
            end else begin
                r_ovld <= tail_vld;
                r_out  <= tail_dat;
            end
        end else if (en && tail_vld) begin
            r_skd_vld <= 1'b1;
            r_skd     <= tail_dat;
        end
    end

    assign o_valid = r_ovld;
    assign o_out   = r_out;

endmodule

### tb/sv/vpp_checker.sv
`timescale 1ns / 100ps

module vpp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  vpp_pkg::t_vpp_in   i_in,
    input  logic               o_valid,
    input  logic               i_ready,
    input  vpp_pkg::t_vpp_out  o_out,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [vpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vpp_pkg::ROW_W-1:0]     i_cfg_data,
    output int                 o_fail_cnt,
    output int                 o_pending,
    output int                 o_vtx_cnt,
    output int                 o_culled_cnt,
    output int                 o_sat_cnt
);
    import vpp_pkg::*;

    localparam int FRAC = 4;

    // shadow copy of the matrix and surface registers
    logic [ROW_W-1:0]  row_x, row_y, row_w;
    logic [SIZE_W-1:0] surf_w, surf_h;

    t_vpp_out screen_q[$];

    // one row times (x, y, z, 1), 20 fraction bits
    function automatic longint row_dot(logic [ROW_W-1:0] row, t_vpp_in v);
        longint cx, cy, cz, cc;
        cx = longint'($signed(row[15:0]));
        cy = longint'($signed(row[31:16]));
        cz = longint'($signed(row[47:32]));
        cc = longint'($signed(row[63:48]));
        return cx * longint'(v.pos_x) + cy * longint'(v.pos_y)
             + cz * longint'(v.pos_z) + cc * 256;
    endfunction

    // viewport scale, round half up, clamp to 24 bits
    function automatic logic [OUT_W-1:0] map_pixel(longint t, longint d,
                                                   logic [SIZE_W-1:0] size,
                                                   inout logic sat);
        longint num, den, q;
        num = 2 * t * (longint'(size) << FRAC) + d;
        den = 2 * d;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        if (q > 64'sd8388607) begin
            q = 8388607;
            sat = 1'b1;
        end else if (q < -64'sd8388608) begin
            q = -8388608;
            sat = 1'b1;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic t_vpp_out project_vertex(t_vpp_in v);
        t_vpp_out r;
        longint cx, cy, cw;
        logic sat;
        r = '0;
        sat = 1'b0;
        cx = row_dot(row_x, v);
        cy = row_dot(row_y, v);
        cw = row_dot(row_w, v);
        if (cw > 0) begin
            r.screen_x = map_pixel(cx + cw, 2 * cw, surf_w, sat);
            r.screen_y = map_pixel(cw - cy, 2 * cw, surf_h, sat);
            r.visible = 1'b1;
            r.saturated = sat;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        o_fail_cnt++;
    endtask

    always_comb o_pending = screen_q.size();

    // watch the channels at the rising edge
    always @(posedge i_clk) begin
        t_vpp_out want;
        if (!i_rst_n) begin
            row_x <= ROW_X_RST;
            row_y <= ROW_Y_RST;
            row_w <= ROW_W_RST;
            surf_w <= WIDTH_RST;
            surf_h <= HEIGHT_RST;
            screen_q.delete();
            o_fail_cnt = 0;
            o_vtx_cnt <= 0;
            o_culled_cnt <= 0;
            o_sat_cnt <= 0;
        end else begin
            // result request
            if (o_valid && i_ready) begin
                if (screen_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = screen_q.pop_front();
                    if (o_out.screen_x !== want.screen_x)
                        report_mismatch("screen_x", o_out.screen_x, want.screen_x);
                    if (o_out.screen_y !== want.screen_y)
                        report_mismatch("screen_y", o_out.screen_y, want.screen_y);
                    if (o_out.visible !== want.visible)
                        report_mismatch("visible", o_out.visible, want.visible);
                    if (o_out.saturated !== want.saturated)
                        report_mismatch("saturated", o_out.saturated, want.saturated);
                end
            end
            // vertex request
            if (i_valid && o_ready) begin
                want = project_vertex(i_in);
                screen_q.insert(screen_q.size(), want);
                o_vtx_cnt <= o_vtx_cnt + 1;
                if (!want.visible) o_culled_cnt <= o_culled_cnt + 1;
                if (want.saturated) o_sat_cnt <= o_sat_cnt + 1;
            end
            // register write
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROW_X:  row_x <= i_cfg_data;
                    CFG_ROW_Y:  row_y <= i_cfg_data;
                    CFG_ROW_W:  row_w <= i_cfg_data;
                    CFG_WIDTH:  surf_w <= i_cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT: surf_h <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/tb_vertex_perspective_projector_core.sv
`timescale 1ns / 100ps

module tb_vertex_perspective_projector_core;
    import vpp_pkg::*;

    localparam int LATENCY   = 32;
    localparam int LIMIT_CYC = 400000;
    localparam int N_RANDOM  = 1030;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_vpp_in i_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_vpp_out o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ROW_W-1:0] i_cfg_data = '0;

    int fail_cnt, pending, vtx_cnt, culled_cnt, sat_cnt;
    int cyc = 0;
    int cfg_writes = 0;
    bit no_idle = 1'b0;
    bit hold_off = 1'b0;

    vertex_perspective_projector_core u_dut (.*);

    vpp_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_in, .o_valid, .i_ready, .o_out,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_vtx_cnt(vtx_cnt),
        .o_culled_cnt(culled_cnt), .o_sat_cnt(sat_cnt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYC) begin
            $display("vertex_perspective_projector_core test failed");
            $finish;
        end
    end

    // receiver: random stalls, none while no_idle, all while hold_off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    // long receiver hold-off, counted in its own process
    initial begin
        wait (vtx_cnt > 300);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (200) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // valid stays high between back-to-back vertices, drops only while idling
    task automatic send_vertex(t_vpp_in v);
        if (!no_idle) begin
            while ($urandom_range(99) < 38) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in <= v;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pipe;
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [ROW_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    function automatic logic [ROW_W-1:0] pack_row(int cx, int cy, int cz, int cc);
        return {cc[15:0], cz[15:0], cy[15:0], cx[15:0]};
    endfunction

    function automatic t_vpp_in make_vertex(int x, int y, int z);
        t_vpp_in v;
        v.pos_x = x[15:0];
        v.pos_y = y[15:0];
        v.pos_z = z[15:0];
        return v;
    endfunction

    // mostly small positions, sometimes full-range bit patterns
    function automatic t_vpp_in rand_vertex();
        if ($urandom_range(3) == 0)
            return make_vertex($urandom, $urandom, $urandom);
        return make_vertex($urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
                           $urandom_range(2048) - 1024);
    endfunction

    task automatic run_random(int n);
        repeat (n) send_vertex(rand_vertex());
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset matrix and extremes
        send_vertex(make_vertex(0, 0, 0));
        send_vertex(make_vertex(32767, 32767, 32767));
        send_vertex(make_vertex(-32768, -32768, -32768));
        send_vertex(make_vertex(256, -256, 0));
        send_vertex(make_vertex(-1, 1, 12345));
        drain_pipe();
        // perspective: w from z, culled when z not positive
        write_reg(CFG_ROW_W, pack_row(0, 0, 4096, 0));
        send_vertex(make_vertex(256, 256, 256));
        send_vertex(make_vertex(100, -100, 0));
        send_vertex(make_vertex(100, -100, -256));
        send_vertex(make_vertex(32767, -32768, 1));
        send_vertex(make_vertex(-32768, 32767, 1));
        send_vertex(make_vertex(5, 7, 32767));
        drain_pipe();
        // zero and oversized surface, unknown index ignored
        write_reg(CFG_WIDTH, 64'd0);
        write_reg(CFG_HEIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(t_cfg_idx'(3'd7), 64'hDEAD_BEEF);
        send_vertex(make_vertex(128, 128, 512));
        send_vertex(make_vertex(-300, 300, 1));
        drain_pipe();
        // extreme coefficients
        write_reg(CFG_ROW_X, pack_row(32767, -32768, 32767, -32768));
        write_reg(CFG_ROW_Y, pack_row(-32768, 32767, -32768, 32767));
        write_reg(CFG_ROW_W, pack_row(1, 0, 0, 1));
        write_reg(CFG_WIDTH, 64'd4096);
        write_reg(CFG_HEIGHT, 64'd1);
        send_vertex(make_vertex(32767, 32767, 0));
        send_vertex(make_vertex(-32768, 1, 0));
        send_vertex(make_vertex(0, 0, 0));
        drain_pipe();

        // random phases over several settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_ROW_X, pack_row(4096, 0, 0, 0));
                    write_reg(CFG_ROW_Y, pack_row(0, 4096, 0, 0));
                    write_reg(CFG_ROW_W, pack_row(0, 0, 4096, 8192));
                    write_reg(CFG_WIDTH, 64'd640);
                    write_reg(CFG_HEIGHT, 64'd480);
                end
                4: begin
                    write_reg(CFG_WIDTH, 64'd1);
                    write_reg(CFG_HEIGHT, 64'd4096);
                end
                default: begin
                    write_reg(CFG_ROW_X, {$urandom, $urandom});
                    write_reg(CFG_ROW_Y, {$urandom, $urandom});
                    write_reg(CFG_ROW_W, pack_row($urandom_range(512) - 256,
                        $urandom_range(512) - 256, $urandom_range(8192),
                        $urandom_range(16384)));
                    write_reg(CFG_WIDTH, $urandom_range(4096, 1));
                    write_reg(CFG_HEIGHT, $urandom_range(4096, 1));
                end
            endcase
            no_idle = (ph == 2);
            run_random(N_RANDOM / 5);
            no_idle = 1'b0;
            drain_pipe();
        end

        $display("covered %0d vertices (%0d culled, %0d clamped), %0d register writes",
                 vtx_cnt, culled_cnt, sat_cnt, cfg_writes);
        if (fail_cnt == 0) begin
            $display("vertex_perspective_projector_core test passed");
        end else begin
            $display("vertex_perspective_projector_core test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/vpp_pkg.sv
rtl/vpp_dot.sv
rtl/vpp_map.sv
rtl/vpp_div.sv
rtl/vertex_perspective_projector_core.sv
tb/sv/vpp_checker.sv
tb/sv/tb_vertex_perspective_projector_core.sv
